// ----- src/rgma_pkg.sv -----
// Package for the range-gated moving average block.
// Holds the shared types, register indexes and widths; depends on nothing.
`default_nettype none

package rgma_pkg;

    localparam int DATA_W = 16;
    localparam int WIN_W  = 5;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_LOW_LIMIT  = 3'd0;
    localparam logic [2:0] REG_HIGH_LIMIT = 3'd1;
    localparam logic [2:0] REG_GAIN       = 3'd2;
    localparam logic [2:0] REG_OFFSET     = 3'd3;
    localparam logic [2:0] REG_WINDOW_LEN = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MULT,
        ST_CALIB,
        ST_UPDATE,
        ST_FULL,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] low_limit;
        logic signed [DATA_W-1:0] high_limit;
        logic signed [DATA_W-1:0] gain;
        logic signed [DATA_W-1:0] offset;
        logic        [WIN_W-1:0]  win;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic read_old;
        logic mult;
        logic calib;
        logic update;
        logic div_start;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic full;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/rgma_ctrl.sv -----
// Controller state machine of the range-gated moving average.
// Sequences the datapath through commands; uses rgma_pkg.
`default_nettype none

module rgma_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rgma_pkg::dp_status_t  status,
    output rgma_pkg::dp_cmd_t          cmd
);

    rgma_pkg::state_t state_reg;
    rgma_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rgma_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rgma_pkg::ST_CHECK;
                end
            end
            rgma_pkg::ST_CHECK: begin
                state_next = status.in_range ? rgma_pkg::ST_MULT : rgma_pkg::ST_IDLE;
            end
            rgma_pkg::ST_MULT:   state_next = rgma_pkg::ST_CALIB;
            rgma_pkg::ST_CALIB:  state_next = rgma_pkg::ST_UPDATE;
            rgma_pkg::ST_UPDATE: state_next = rgma_pkg::ST_FULL;
            rgma_pkg::ST_FULL: begin
                state_next = status.full ? rgma_pkg::ST_DIVIDE : rgma_pkg::ST_IDLE;
            end
            rgma_pkg::ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = rgma_pkg::ST_DELIVER;
                end
            end
            rgma_pkg::ST_DELIVER: begin
                if (status.out_free) begin
                    state_next = rgma_pkg::ST_IDLE;
                end
            end
            default: state_next = rgma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rgma_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            rgma_pkg::ST_CHECK:   cmd.read_old  = status.in_range;
            rgma_pkg::ST_MULT:    cmd.mult      = 1'b1;
            rgma_pkg::ST_CALIB:   cmd.calib     = 1'b1;
            rgma_pkg::ST_UPDATE:  cmd.update    = 1'b1;
            rgma_pkg::ST_FULL:    cmd.div_start = status.full;
            rgma_pkg::ST_DIVIDE:  cmd.div_step  = 1'b1;
            rgma_pkg::ST_DELIVER: cmd.out_load  = status.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/rgma_dp.sv -----
// Datapath of the range-gated moving average: range check, calibration,
// history ring with running sum, bit-serial divider and output register.
// Depends on rgma_pkg.
`default_nettype none

module rgma_dp #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire rgma_pkg::cfg_t              cfg,
    input  wire logic                        cfg_clear,
    input  wire rgma_pkg::dp_cmd_t           cmd,
    output rgma_pkg::dp_status_t             status,
    input  wire logic signed [15:0]          s_sample,
    input  wire logic                        s_restart,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [15:0]               m_average
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = 17 + $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int CMP_W  = 9;

    logic signed [15:0]       hist_mem [MAX_WINDOW];

    logic signed [15:0]       sample_reg;
    logic signed [31:0]       product_reg;
    logic signed [15:0]       cal_reg;
    logic signed [15:0]       old_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        slot_wrap;
    logic [SLOT_W:0]          slot_inc;
    logic [SLOT_W-1:0]        slot_next;
    logic [4:0]               fill_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         dvd_reg;
    logic [SUM_W-1:0]         mag;
    logic [4:0]               rem_reg;
    logic [5:0]               trial;
    logic                     take;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic                     m_valid_reg;
    logic signed [15:0]       avg_reg;
    logic signed [19:0]       scaled;
    logic signed [20:0]       cal_sum;
    logic signed [15:0]       cal_sat;
    logic signed [15:0]       quot16;
    logic                     clear_hist;
    logic                     window_full;

    assign clear_hist = cfg_clear | (cmd.capture & s_restart);

    assign slot_wrap = (CMP_W'(slot_reg) >= CMP_W'(cfg.win)) ? '0 : slot_reg;
    assign slot_inc  = {1'b0, slot_reg} + 1'b1;
    assign slot_next = (CMP_W'(slot_inc) >= CMP_W'(cfg.win)) ? '0 : slot_inc[SLOT_W-1:0];

    assign window_full = (fill_reg >= cfg.win);

    // Floor of product / 4096 is the arithmetic shift, then offset and clamp.
    assign scaled  = product_reg[31:12];
    assign cal_sum = {scaled[19], scaled} + {{5{cfg.offset[15]}}, cfg.offset};
    always_comb begin
        if (cal_sum > 21'sd32767) begin
            cal_sat = 16'sh7FFF;
        end else if (cal_sum < -21'sd32768) begin
            cal_sat = -16'sh8000;
        end else begin
            cal_sat = cal_sum[15:0];
        end
    end

    always_comb begin
        if (window_full) begin
            sum_next = sum_reg + {{(SUM_W-16){cal_reg[15]}}, cal_reg}
                               - {{(SUM_W-16){old_reg[15]}}, old_reg};
        end else begin
            sum_next = sum_reg + {{(SUM_W-16){cal_reg[15]}}, cal_reg};
        end
    end

    assign mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign take  = (trial >= {1'b0, cfg.win});

    assign quot16 = dvd_reg[15:0];

    // Ring storage; an old entry enters the sum only after it was written.
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            hist_mem[slot_reg] <= cal_reg;
        end
        if (cmd.read_old) begin
            old_reg <= hist_mem[slot_wrap];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (clear_hist) begin
                slot_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end else if (cmd.read_old) begin
                slot_reg <= slot_wrap;
            end else if (cmd.update) begin
                slot_reg <= slot_next;
                sum_reg  <= sum_next;
                if (!window_full) begin
                    fill_reg <= fill_reg + 5'd1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_sample;
        end
        if (cmd.mult) begin
            product_reg <= sample_reg * cfg.gain;
        end
        if (cmd.calib) begin
            cal_reg <= cal_sat;
        end
        // Restoring division: the quotient bits shift in where dividend bits leave.
        if (cmd.div_start) begin
            dvd_reg <= mag + {{(SUM_W-4){1'b0}}, cfg.win[4:1]};
            rem_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], take};
            rem_reg <= take ? 5'(trial - {1'b0, cfg.win}) : trial[4:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load) begin
            avg_reg <= neg_reg ? -quot16 : quot16;
        end
    end

    always_comb begin
        status.in_range = (sample_reg >= cfg.low_limit) && (sample_reg <= cfg.high_limit);
        status.full     = window_full;
        status.div_done = (cnt_reg == CNT_W'(SUM_W - 1));
        status.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid   = m_valid_reg;
    assign m_average = avg_reg;

endmodule

`default_nettype wire

// ----- src/range_gated_moving_average.sv -----
// Range-gated moving average. An out-of-range item is dropped after the range
// check, an item that leaves the window unfilled passes calibration and the ring
// update, and an item that yields a result also runs through the one-bit-per-cycle
// divider before it is loaded into the output register.
// The output register lets the next item be accepted while a result waits.
// Synchronous active-low reset restores register defaults and empties the window.
`default_nettype none

module range_gated_moving_average #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_sample,
    input  wire logic                 s_restart,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_average
);

    logic signed [15:0]    low_limit_reg;
    logic signed [15:0]    high_limit_reg;
    logic signed [15:0]    gain_reg;
    logic signed [15:0]    offset_reg;
    logic [4:0]            window_len_reg;
    logic [4:0]            eff_win;
    logic [2:0]            reg_idx;
    logic                  wr_en;
    logic                  cfg_clear;
    rgma_pkg::cfg_t        cfg;
    rgma_pkg::dp_cmd_t     cmd;
    rgma_pkg::dp_status_t  status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg_clear = wr_en && (reg_idx == rgma_pkg::REG_WINDOW_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= -16'sh8000;
            high_limit_reg <= 16'sh7FFF;
            gain_reg       <= 16'sh1000;
            offset_reg     <= '0;
            window_len_reg <= 5'd4;
        end else if (wr_en) begin
            case (reg_idx)
                rgma_pkg::REG_LOW_LIMIT:  low_limit_reg  <= pwdata[15:0];
                rgma_pkg::REG_HIGH_LIMIT: high_limit_reg <= pwdata[15:0];
                rgma_pkg::REG_GAIN:       gain_reg       <= pwdata[15:0];
                rgma_pkg::REG_OFFSET:     offset_reg     <= pwdata[15:0];
                rgma_pkg::REG_WINDOW_LEN: window_len_reg <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rgma_pkg::REG_LOW_LIMIT:  prdata = {{16{low_limit_reg[15]}}, low_limit_reg};
            rgma_pkg::REG_HIGH_LIMIT: prdata = {{16{high_limit_reg[15]}}, high_limit_reg};
            rgma_pkg::REG_GAIN:       prdata = {{16{gain_reg[15]}}, gain_reg};
            rgma_pkg::REG_OFFSET:     prdata = {{16{offset_reg[15]}}, offset_reg};
            rgma_pkg::REG_WINDOW_LEN: prdata = {27'd0, window_len_reg};
            default:                  prdata = '0;
        endcase
    end

    // A window length of zero acts as one; longer than the ring acts as the ring.
    always_comb begin
        if (window_len_reg == 5'd0) begin
            eff_win = 5'd1;
        end else if (9'(window_len_reg) > 9'(MAX_WINDOW)) begin
            eff_win = 5'(MAX_WINDOW);
        end else begin
            eff_win = window_len_reg;
        end
    end

    always_comb begin
        cfg.low_limit  = low_limit_reg;
        cfg.high_limit = high_limit_reg;
        cfg.gain       = gain_reg;
        cfg.offset     = offset_reg;
        cfg.win        = eff_win;
    end

    rgma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rgma_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .cmd       (cmd),
        .status    (status),
        .s_sample  (s_sample),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_average (m_average)
    );

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while holding an item");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new item accepted while one is in work");

    a_div_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> status.full)
        else $error("division started before the window is full");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for range_gated_moving_average: drives samples and APB writes.
// A window-mean tracker class predicts every average; depends on rgma_pkg and the RTL.

module testbench;

    localparam int WINDOW_MAX = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD = 300;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 90;
    localparam int TIMEOUT_NS = 2_000_000;

    // Predicts the filter output from accepted samples and register writes.
    class window_mean_tracker;
        logic signed [15:0] lo_lim;
        logic signed [15:0] hi_lim;
        logic signed [15:0] gain_q12;
        logic signed [15:0] offset_val;
        logic [4:0]         win_len;
        logic signed [15:0] ring [WINDOW_MAX];
        logic [3:0]         slot;
        logic [4:0]         held;
        logic signed [20:0] sum;
        logic signed [15:0] pending_means [$];
        int fail_count;
        int samples_seen;
        int samples_dropped;
        int means_checked;

        function new();
            lo_lim = -16'sd32768;
            hi_lim = 16'sd32767;
            gain_q12 = 16'sd4096;
            offset_val = '0;
            win_len = 5'd4;
            foreach (ring[i]) ring[i] = '0;
            fail_count = 0;
            samples_seen = 0;
            samples_dropped = 0;
            means_checked = 0;
            clear_window();
        endfunction

        function void clear_window();
            slot = '0;
            held = '0;
            sum = '0;
        endfunction

        function void apply_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                rgma_pkg::REG_LOW_LIMIT:  lo_lim = value[15:0];
                rgma_pkg::REG_HIGH_LIMIT: hi_lim = value[15:0];
                rgma_pkg::REG_GAIN:       gain_q12 = value[15:0];
                rgma_pkg::REG_OFFSET:     offset_val = value[15:0];
                rgma_pkg::REG_WINDOW_LEN: begin
                    win_len = value[4:0];
                    clear_window();
                end
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                rgma_pkg::REG_LOW_LIMIT:  return {16'h0, lo_lim};
                rgma_pkg::REG_HIGH_LIMIT: return {16'h0, hi_lim};
                rgma_pkg::REG_GAIN:       return {16'h0, gain_q12};
                rgma_pkg::REG_OFFSET:     return {16'h0, offset_val};
                default:                  return {27'h0, win_len};
            endcase
        endfunction

        function void note_sample(logic signed [15:0] smp, logic rst);
            int w;
            int cal;
            int total;
            int mag;
            int mean;
            samples_seen++;
            w = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : int'(win_len));
            if (rst) clear_window();
            if (smp < lo_lim || smp > hi_lim) begin
                samples_dropped++;
                return;
            end
            // The arithmetic shift gives the floor of the product by the Q4.12 gain.
            cal = ((int'(smp) * int'(gain_q12)) >>> 12) + int'(offset_val);
            if (cal > 32767) cal = 32767;
            if (cal < -32768) cal = -32768;
            if (slot >= w) slot = '0;
            if (held >= w) sum = sum - ring[slot];
            else held = held + 5'd1;
            ring[slot] = cal[15:0];
            sum = sum + cal;
            slot = slot + 4'd1;
            if (slot >= w) slot = '0;
            if (held < w) return;
            total = int'(sum);
            mag = (total < 0) ? -total : total;
            mean = (mag + w / 2) / w;
            if (total < 0) mean = -mean;
            pending_means.insert(pending_means.size(), mean[15:0]);
        endfunction

        function void check_average(logic signed [15:0] actual);
            logic signed [15:0] want;
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected average, expected none, got %0d", $time, actual);
                fail_count++;
                return;
            end
            want = pending_means.pop_front();
            means_checked++;
            if (actual !== want) begin
                $display("%0t: average mismatch, expected %0d, got %0d", $time, want, actual);
                fail_count++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample = '0;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_average;

    window_mean_tracker tracker;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    range_gated_moving_average u_top (.*);

    always #2 aclk = ~aclk;

    // The receiver stalls at random, and for a long stretch whenever one is requested.
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_average(m_average);
            if (s_valid && s_ready) tracker.note_sample(s_sample, s_restart);
        end
    end

    task automatic apb_transfer(input logic is_write, input logic [2:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Writes a register with junk above its width, then reads it back.
    task automatic program_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] mask;
        logic [31:0] word;
        logic [31:0] got;
        mask = (idx == rgma_pkg::REG_WINDOW_LEN) ? 32'h1F : 32'hFFFF;
        word = ($urandom() & ~mask) | ({16'h0, value} & mask);
        apb_transfer(1'b1, idx, word, got);
        tracker.apply_reg(idx, word);
        apb_transfer(1'b0, idx, 32'h0, got);
        if ((got & mask) !== (tracker.reg_value(idx) & mask)) begin
            $display("%0t: register %0d readback, expected %h, got %h", $time, idx,
                     tracker.reg_value(idx) & mask, got & mask);
            tracker.fail_count++;
        end
    endtask

    task automatic set_filter(input int lo, input int hi, input int g, input int off,
                              input int win);
        program_reg(rgma_pkg::REG_LOW_LIMIT, lo[15:0]);
        program_reg(rgma_pkg::REG_HIGH_LIMIT, hi[15:0]);
        program_reg(rgma_pkg::REG_GAIN, g[15:0]);
        program_reg(rgma_pkg::REG_OFFSET, off[15:0]);
        program_reg(rgma_pkg::REG_WINDOW_LEN, {11'h0, win[4:0]});
    endtask

    task automatic offer_sample(input logic [15:0] smp, input logic rst);
        @(negedge aclk);
        if (send_idle_pct != 0 && $urandom_range(15, 0) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(40, 1)) @(negedge aclk);
        end
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_restart <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops offering items until every predicted average has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        int lo;
        int hi;
        lo = tracker.lo_lim;
        hi = tracker.hi_lim;
        case ($urandom_range(9, 0))
            0: return $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
            1: return 16'(lo + int'($urandom_range(2, 0)) - 1);
            2: return 16'(hi + int'($urandom_range(2, 0)) - 1);
            3, 4: return 16'($urandom());
            default: begin
                if (lo <= hi) return 16'(lo + int'($urandom_range(hi - lo, 0)));
                return 16'($urandom());
            end
        endcase
    endfunction

    initial begin
        int lo;
        int hi;
        int g;
        int off;
        int win;
        int a;
        int b;
        int n;
        tracker = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: saturated extremes, then a tie that rounds away from zero.
        repeat (4) offer_sample(16'h7FFF, 1'b0);
        repeat (2) offer_sample(16'h8000, 1'b0);
        offer_sample(16'h0000, 1'b1);
        offer_sample(16'h0000, 1'b0);
        offer_sample(16'h0000, 1'b0);
        offer_sample(16'h0002, 1'b0);
        offer_sample(16'hFFFC, 1'b0);
        wait_drained();

        // Narrow range with extreme gain and offset; a dropped restart still clears.
        set_filter(-1000, 1000, -32768, 32767, 2);
        offer_sample(-16'sd1000, 1'b0);
        offer_sample(16'sd1000, 1'b0);
        offer_sample(-16'sd1001, 1'b0);
        offer_sample(16'sd1001, 1'b1);
        offer_sample(16'sd500, 1'b0);
        offer_sample(-16'sd500, 1'b0);
        offer_sample(16'h8000, 1'b0);
        offer_sample(16'h7FFF, 1'b0);
        offer_sample(16'sd999, 1'b0);
        offer_sample(16'sd0, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_filter(-32768, 32767, 4096, 0, 16);
                1: set_filter(-32768, 32767, 32767, -32768, 0);
                2: set_filter(-32768, 32767, -32768, 32767, 31);
                3: set_filter(-20000, 20000, 2048, 100, 1);
                4: set_filter(100, -100, 4096, 0, 3);
                default: begin
                    if ($urandom_range(1, 0)) begin
                        lo = -32768 + int'($urandom_range(10000, 0));
                        hi = 32767 - int'($urandom_range(10000, 0));
                    end else begin
                        a = int'($urandom_range(65535, 0)) - 32768;
                        b = int'($urandom_range(65535, 0)) - 32768;
                        lo = (a < b) ? a : b;
                        hi = (a < b) ? b : a;
                    end
                    if ($urandom_range(1, 0)) g = 4096 + int'($urandom_range(4096, 0)) - 2048;
                    else g = int'($urandom_range(65535, 0)) - 32768;
                    if ($urandom_range(1, 0)) off = int'($urandom_range(2000, 0)) - 1000;
                    else off = int'($urandom_range(65535, 0)) - 32768;
                    if ($urandom_range(3, 0) == 0) win = $urandom_range(31, 0);
                    else win = $urandom_range(8, 1);
                    set_filter(lo, hi, g, off, win);
                end
            endcase
            @(posedge aclk);
            send_idle_pct = (p % 4 == 1) ? 53 : ((p % 4 == 3) ? 24 : 0);
            recv_stall_pct = (p % 4 == 2) ? 53 : ((p % 4 == 3) ? 24 : 0);
            // The empty range drops everything, so that phase stays short.
            n = (p == 4) ? 30 : PHASE_ITEMS;
            for (int i = 0; i < n; i++) begin
                offer_sample(pick_sample(), $urandom_range(99, 0) < 3);
                if ((p == 1 && i == 20) || (p == 6 && i == 50)) hold_requests++;
                if (p == 5 && i == 45) wait_drained();
            end
            wait_drained();
        end

        $display("Covered %0d samples (%0d out of range) over %0d filter settings.",
                 tracker.samples_seen, tracker.samples_dropped, NUM_PHASES + 2);
        $display("Checked %0d averages under four idle and stall patterns.",
                 tracker.means_checked);
        if (tracker.fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout while waiting for the block", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
